>>> design/rmf_pkg.sv
`default_nettype none

package rmf_pkg;

	localparam int unsigned MAX_WINDOW_DEF  = 31;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	localparam int POS_BITS      = 16;
	localparam int K_BITS        = POS_BITS + 3;
	localparam int WIDTH_BITS    = 5;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 1;
	localparam int MAX_OUT       = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_LENGTH  = 1'd1;

	localparam logic [WIDTH_BITS-1:0] WINDOW_WIDTH_RESET = 5'd3;
	localparam logic [POS_BITS-1:0]   LINE_LENGTH_RESET  = 16'd256;

	typedef struct packed {
		logic valid;
		logic clear;
	} rmf_ins_ctl_t;

	typedef struct packed {
		logic [POS_BITS-1:0] pos;
		logic [POS_BITS-1:0] oldest;
	} rmf_line_ctx_t;

endpackage

`default_nettype wire

>>> design/rmf_if.sv
`default_nettype none

interface rmf_sample_if #(
	parameter int unsigned SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface rmf_median_if #(
	parameter int unsigned SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] median;
	logic                          end_of_line;

	modport source(output valid, output median, output end_of_line, input ready);
	modport sink(input valid, input median, input end_of_line, output ready);
endinterface

`default_nettype wire

>>> design/rmf_sort_cell.sv
`default_nettype none

module rmf_sort_cell #(
	parameter int unsigned SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          ins,
	input  wire logic                          clr,
	input  wire logic signed [SAMPLE_BITS-1:0] data,
	input  wire logic signed [SAMPLE_BITS-1:0] left_q,
	input  wire logic                          left_valid,
	input  wire logic                          left_b,
	output logic signed [SAMPLE_BITS-1:0]      q,
	output logic                               valid,
	output logic                               b
);

	logic signed [SAMPLE_BITS-1:0] q_q;
	logic                          val_q;
	logic                          valid_eff;
	logic                          b_o;

	// A cell moves when the new value belongs at or before it; it then takes
	// either its left neighbor or, at the insertion point, the new value.
	always_comb begin
		valid_eff = val_q & ~clr;
		b_o       = ~valid_eff | (q_q > data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= 1'b0;
		end else if (ins && b_o) begin
			val_q <= left_b ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ins && b_o) begin
			q_q <= left_b ? left_q : data;
		end
	end

	assign q     = q_q;
	assign valid = valid_eff;
	assign b     = b_o;

endmodule

`default_nettype wire

>>> design/rmf_sort_chain.sv
`default_nettype none

module rmf_sort_chain #(
	parameter int unsigned NCELL       = 31,
	parameter int unsigned SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rmf_pkg::rmf_ins_ctl_t         ctl,
	input  wire logic signed [SAMPLE_BITS-1:0] data,
	input  wire logic [$clog2(NCELL)-1:0]      mid,
	output logic signed [SAMPLE_BITS-1:0]      median
);

	logic signed [SAMPLE_BITS-1:0] cq [NCELL];
	logic                          cv [NCELL];
	logic                          cb [NCELL];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		if (i == 0) begin : g_head
			rmf_sort_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ins       (ctl.valid),
				.clr       (ctl.clear),
				.data      (data),
				.left_q    ('0),
				.left_valid(1'b0),
				.left_b    (1'b0),
				.q         (cq[i]),
				.valid     (cv[i]),
				.b         (cb[i])
			);
		end else begin : g_body
			rmf_sort_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ins       (ctl.valid),
				.clr       (ctl.clear),
				.data      (data),
				.left_q    (cq[i-1]),
				.left_valid(cv[i-1]),
				.left_b    (cb[i-1]),
				.q         (cq[i]),
				.valid     (cv[i]),
				.b         (cb[i])
			);
		end
	end

	assign median = cq[mid];

endmodule

`default_nettype wire

>>> design/rmf_addr_gen.sv
`default_nettype none

module rmf_addr_gen #(
	parameter int unsigned MAX_WINDOW = rmf_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic signed [rmf_pkg::K_BITS-1:0]  k,
	input  wire rmf_pkg::rmf_ins_ctl_t              ctl,
	input  wire rmf_pkg::rmf_line_ctx_t             ctx,
	input  wire logic [$clog2(MAX_WINDOW)-1:0]      wp,
	output logic [$clog2(MAX_WINDOW)-1:0]           addr,
	output rmf_pkg::rmf_ins_ctl_t                   ctl_out,
	output logic                                    busy
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int KB = rmf_pkg::K_BITS;

	logic signed [KB-1:0] pos_s;
	logic signed [KB-1:0] old_s;
	logic signed [KB-1:0] n2m1;
	logic signed [KB-1:0] kl;
	logic signed [KB-1:0] km;
	logic signed [KB-1:0] km_s1;
	logic signed [KB-1:0] kc1;
	logic signed [KB-1:0] kc;
	logic [AW-1:0]        d;
	logic [AW:0]          t;
	logic [AW-1:0]        addr_n;
	logic [AW-1:0]        addr_s2;

	rmf_pkg::rmf_ins_ctl_t ctl_s1;
	rmf_pkg::rmf_ins_ctl_t ctl_s2;

	// First stage: mirror about the start and about the end of the line.
	always_comb begin
		pos_s = signed'(KB'(ctx.pos));
		old_s = signed'(KB'(ctx.oldest));
		n2m1  = signed'(KB'({ctx.pos, 1'b1}));
		kl    = k[KB-1] ? ~k : k;
		km    = (kl > pos_s) ? (n2m1 - kl) : kl;
	end

	// Second stage: clamp into the part of the line that the history holds,
	// then turn the distance from the newest sample into a ring slot.
	always_comb begin
		kc1 = (km_s1 > pos_s) ? pos_s : km_s1;
		kc  = (kc1 < old_s) ? old_s : kc1;
		d   = ctx.pos[AW-1:0] - kc[AW-1:0];
		t   = {1'b0, wp} - {1'b0, d};
		if (t[AW]) begin
			addr_n = AW'(t + (AW+1)'(MAX_WINDOW));
		end else begin
			addr_n = t[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		km_s1   <= km;
		addr_s2 <= addr_n;
	end

	assign addr    = addr_s2;
	assign ctl_out = ctl_s2;
	assign busy    = ctl_s1.valid | ctl_s2.valid;

endmodule

`default_nettype wire

>>> design/running_median_filter_1d.sv
// Running median over a line of signed samples.
// Samples enter one per beat on the samples channel; medians leave on the
// medians channel, one beat per line position, the last of a line marked by
// end_of_line. Outputs lag the input by half a window; the beat that carries
// the final sample of a line releases every median still owed.
// Each median is built by streaming the window's samples out of the
// history memory into a chain of sorting cells, one sample per cycle,
// through the address generator's mirror and clamp stages and the memory
// read; the median is then loaded into the output register.
// A sample that releases no median leaves the block idle; one that
// releases medians, such as the final sample of a line, blocks the input
// until the last of them is loaded into the output register.
// The output register holds one median; while the receiver stalls, the
// next median waits in the sorting chain and the input stays blocked, but
// a new sample is taken once the last median of a beat sits in the register.
// Reset clears the line position and output valid and restores a window of
// three and a line length of 256. The user must write configuration through
// cfg_wr_en, cfg_index and cfg_data while idle; the block never checks it.
`default_nettype none

module running_median_filter_1d #(
	parameter int unsigned MAX_WINDOW  = rmf_pkg::MAX_WINDOW_DEF,
	parameter int unsigned SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	rmf_sample_if.sink                               samples,
	rmf_median_if.source                             medians,
	input  wire logic                                cfg_wr_en,
	input  wire logic [rmf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [rmf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int AW      = $clog2(MAX_WINDOW);
	localparam int MID_CAP = (MAX_WINDOW - 1) / 2;
	localparam int NCELL   = 2 * MID_CAP + 1;
	localparam int CIW     = $clog2(NCELL);
	localparam int KB      = rmf_pkg::K_BITS;
	localparam int PB      = rmf_pkg::POS_BITS;
	localparam int WB      = rmf_pkg::WIDTH_BITS;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]           state_q;
	logic [WB-1:0]        cfg_width_q;
	logic [PB-1:0]        cfg_len_q;
	logic [PB-1:0]        pos_q;
	logic [PB-1:0]        c_q;
	logic [PB-1:0]        oldest_q;
	logic [PB-1:0]        oc_q;
	logic [PB-1:0]        last_q;
	logic                 end_q;
	logic [AW-1:0]        wptr_q;
	logic signed [KB-1:0] k_q;
	logic [CIW:0]         ic_q;
	logic                 ov_q;
	logic signed [SAMPLE_BITS-1:0] med_q;
	logic                 eol_q;

	logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rd_s3;
	rmf_pkg::rmf_ins_ctl_t         ctl_s3;

	logic [WB-1:0]   mid_raw;
	logic [CIW-1:0]  mid;
	logic            accept;
	logic [PB:0]     n17;
	logic [PB-1:0]   len_eff;
	logic            is_end;
	logic            has_out;
	logic [PB:0]     start_end;
	logic [PB-1:0]   oc_end;
	logic [PB-1:0]   oc_start;
	logic [AW-1:0]   wptr_inc;
	logic            pipe_busy;
	logic            load_out;
	logic            last_pos;
	logic [PB-1:0]   oc_next;

	rmf_pkg::rmf_ins_ctl_t  iss_ctl;
	rmf_pkg::rmf_ins_ctl_t  ctl_s2;
	rmf_pkg::rmf_line_ctx_t ctx;
	logic [AW-1:0]          addr_s2;
	logic signed [SAMPLE_BITS-1:0] median_c;

	always_comb begin
		mid_raw = (cfg_width_q == '0) ? '0 : ((cfg_width_q - 1'b1) >> 1);
		if (8'(mid_raw) > 8'(MID_CAP)) begin
			mid = CIW'(MID_CAP);
		end else begin
			mid = CIW'(mid_raw);
		end
	end

	always_comb begin
		accept    = samples.valid && (state_q == S_IDLE);
		n17       = (PB+1)'(pos_q) + 1'b1;
		len_eff   = (cfg_len_q == '0) ? PB'(1) : cfg_len_q;
		is_end    = n17 >= (PB+1)'(len_eff);
		has_out   = ((PB+1)'(c_q) + (PB+1)'(mid)) <= (PB+1)'(pos_q);
		start_end = (n17 > (PB+1)'(rmf_pkg::MAX_OUT)) ?
		            (n17 - (PB+1)'(rmf_pkg::MAX_OUT)) : '0;
		oc_end    = (start_end[PB-1:0] > c_q) ? start_end[PB-1:0] : c_q;
		oc_start  = is_end ? oc_end : c_q;
		wptr_inc  = (wptr_q == AW'(MAX_WINDOW - 1)) ? '0 : (wptr_q + 1'b1);
		iss_ctl.valid = (state_q == S_ISSUE);
		iss_ctl.clear = (ic_q == '0);
		ctx.pos    = pos_q;
		ctx.oldest = oldest_q;
		load_out  = (state_q == S_DRAIN) && !pipe_busy && !ctl_s3.valid &&
		            (!ov_q || medians.ready);
		last_pos  = (oc_q == last_q);
		oc_next   = oc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q <= rmf_pkg::WINDOW_WIDTH_RESET;
			cfg_len_q   <= rmf_pkg::LINE_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rmf_pkg::REG_WINDOW_WIDTH: cfg_width_q <= cfg_data[WB-1:0];
				rmf_pkg::REG_LINE_LENGTH:  cfg_len_q   <= cfg_data[PB-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			c_q     <= '0;
			wptr_q  <= '0;
			ov_q    <= 1'b0;
			ctl_s3  <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (medians.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_end || has_out) begin
							state_q <= S_ISSUE;
						end else begin
							pos_q  <= n17[PB-1:0];
							wptr_q <= wptr_inc;
						end
					end
				end
				S_ISSUE: begin
					if (ic_q == {mid, 1'b0}) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (load_out) begin
						if (last_pos) begin
							state_q <= S_IDLE;
							if (end_q) begin
								pos_q  <= '0;
								c_q    <= '0;
								wptr_q <= '0;
							end else begin
								pos_q  <= n17[PB-1:0];
								c_q    <= c_q + 1'b1;
								wptr_q <= wptr_inc;
							end
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			oldest_q <= (pos_q >= PB'(MAX_WINDOW - 1)) ? (pos_q - PB'(MAX_WINDOW - 1)) : '0;
			oc_q     <= oc_start;
			last_q   <= is_end ? pos_q : c_q;
			end_q    <= is_end;
			k_q      <= signed'(KB'(oc_start)) - signed'(KB'(mid));
			ic_q     <= '0;
		end else if (state_q == S_ISSUE) begin
			k_q  <= k_q + 1'b1;
			ic_q <= ic_q + 1'b1;
		end else if (load_out && !last_pos) begin
			oc_q <= oc_next;
			k_q  <= signed'(KB'(oc_next)) - signed'(KB'(mid));
			ic_q <= '0;
		end
		if (load_out) begin
			med_q <= median_c;
			eol_q <= end_q && last_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_mem[wptr_q] <= samples.sample;
		end
		if (ctl_s2.valid) begin
			rd_s3 <= hist_mem[addr_s2];
		end
	end

	rmf_addr_gen #(.MAX_WINDOW(MAX_WINDOW)) u_addr_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.k      (k_q),
		.ctl    (iss_ctl),
		.ctx    (ctx),
		.wp     (wptr_q),
		.addr   (addr_s2),
		.ctl_out(ctl_s2),
		.busy   (pipe_busy)
	);

	rmf_sort_chain #(.NCELL(NCELL), .SAMPLE_BITS(SAMPLE_BITS)) u_sort_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_s3),
		.data  (rd_s3),
		.mid   (mid),
		.median(median_c)
	);

	assign samples.ready       = (state_q == S_IDLE);
	assign medians.valid       = ov_q;
	assign medians.median      = med_q;
	assign medians.end_of_line = eol_q;

`ifndef SYNTHESIS
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(pipe_busy || ctl_s3.valid))
		else $error("window pipeline active while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!ov_q || medians.ready))
		else $error("median register overwritten before its beat");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |-> (ic_q <= {mid, 1'b0}))
		else $error("more window samples issued than the window holds");

	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && end_q && last_pos) |=> (pos_q == '0 && c_q == '0 && wptr_q == '0))
		else $error("line position not cleared after the final median");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top;

	import rmf_pkg::*;

	localparam int HIST_DEPTH   = MAX_WINDOW_DEF;
	localparam int SETTLE_TICKS = 64;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int RANDOM_ITEMS = 400;

	typedef struct {
		logic [15:0] median;
		logic        eol;
	} median_beat_t;

	typedef enum logic [1:0] {ROW_SAMPLE, ROW_WIDTH, ROW_LENGTH} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [15:0] value;
		bit          typed;
		logic [15:0] exp_median;
		bit          exp_eol;
	} row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	rmf_sample_if samples();
	rmf_median_if medians();

	running_median_filter_1d u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.medians   (medians),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Mirror of the filter state, kept in step with every accepted sample beat.
	logic [15:0]  hist_ring [HIST_DEPTH];
	int           line_pos;
	int           next_pos;
	logic [4:0]   width_reg;
	logic [15:0]  length_reg;

	median_beat_t owed_medians [$];
	median_beat_t step_medians [$];
	median_beat_t got_head;

	int errors;
	int cycle_count;
	bit calm;

	row_t plan [38];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [15:0] median_at(int c, int n, int p, int mid);
		logic signed [15:0] vals [HIST_DEPTH];
		logic signed [15:0] v;
		int oldest;
		int i;
		int j;
		int k;
		oldest = p - HIST_DEPTH + 1;
		if (oldest < 0) begin
			oldest = 0;
		end
		for (i = 0; i < 2 * mid + 1; i++) begin
			k = c - mid + i;
			if (k < 0) begin
				k = -1 - k;
			end
			if (k >= n) begin
				k = 2 * n - 1 - k;
			end
			if (k > n - 1) begin
				k = n - 1;
			end
			if (k < oldest) begin
				k = oldest;
			end
			if (k > p) begin
				k = p;
			end
			v = hist_ring[k % HIST_DEPTH];
			j = i;
			while (j > 0 && vals[j-1] > v) begin
				vals[j] = vals[j-1];
				j--;
			end
			vals[j] = v;
		end
		return vals[mid];
	endfunction

	task automatic advance_line(input logic [15:0] s);
		median_beat_t b;
		int p;
		int len;
		int w;
		int mid;
		int n;
		int c;
		p = line_pos;
		len = (length_reg == 16'd0) ? 1 : int'(length_reg);
		w = int'(width_reg);
		if (w < 1) begin
			w = 1;
		end
		if (w % 2 == 0) begin
			w = w - 1;
		end
		if (w > HIST_DEPTH) begin
			w = HIST_DEPTH;
		end
		mid = w / 2;
		n = p + 1;
		c = next_pos;
		hist_ring[p % HIST_DEPTH] = s;
		if (n < len) begin
			if (c + mid <= p) begin
				b.median = median_at(c, n, p, mid);
				b.eol = 1'b0;
				step_medians.push_back(b);
				next_pos = c + 1;
			end
			line_pos = n;
		end else begin
			if (n - c > MAX_OUT) begin
				c = n - MAX_OUT;
			end
			while (c < n) begin
				b.median = median_at(c, n, p, mid);
				b.eol = (c == n - 1);
				step_medians.push_back(b);
				c++;
			end
			line_pos = 0;
			next_pos = 0;
		end
	endtask

	task automatic send_sample(input logic [15:0] s, input bit typed, input median_beat_t typed_beat);
		int gap;
		samples.valid <= 1'b1;
		samples.sample <= s;
		do @(posedge clk); while (samples.ready !== 1'b1);
		step_medians.delete();
		advance_line(s);
		if (typed) begin
			owed_medians.push_back(typed_beat);
		end else begin
			foreach (step_medians[i]) begin
				owed_medians.push_back(step_medians[i]);
			end
		end
		gap = gap_len();
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		while (owed_medians.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
		samples.valid <= 1'b0;
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_WINDOW_WIDTH) begin
			width_reg = data[4:0];
		end else begin
			length_reg = data;
		end
	endtask

	initial begin
		medians.ready <= 1'b0;
		@(posedge clk);
		forever begin
			int n;
			n = gap_len();
			if (n > 0) begin
				medians.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			medians.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && medians.valid === 1'b1 && medians.ready === 1'b1) begin
			if (owed_medians.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected median beat: median %0d end_of_line %b",
						$signed(medians.median), medians.end_of_line);
				end
			end else begin
				got_head = owed_medians.pop_front();
				if (medians.median !== got_head.median ||
						medians.end_of_line !== got_head.eol) begin
					errors++;
					if (errors <= 10) begin
						$display("median mismatch: expected %0d/%b, got %0d/%b",
							$signed(got_head.median), got_head.eol,
							$signed(medians.median), medians.end_of_line);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("running_median_filter_1d test failed");
			$finish;
		end
	end

	initial begin
		median_beat_t blank;
		median_beat_t typed_beat;
		logic [15:0]  value;
		logic [15:0]  base;
		int           sent;
		int           count;
		int           left;
		int           eff_len;
		int           mode;
		int           ramp_step;
		int           pick;

		errors = 0;
		cycle_count = 0;
		calm = 1'b0;
		line_pos = 0;
		next_pos = 0;
		width_reg = WINDOW_WIDTH_RESET;
		length_reg = LINE_LENGTH_RESET;
		blank.median = 16'h0;
		blank.eol = 1'b0;

		samples.valid <= 1'b0;
		samples.sample <= 16'h0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_WINDOW_WIDTH;
		cfg_data <= 16'h0;
		arst_n <= 1'b0;

		plan = '{
			'{ROW_SAMPLE, 16'h0064, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'hFFFB, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h0007, 1'b0, 16'h0000, 1'b0},
			'{ROW_LENGTH, 16'd2,    1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
			'{ROW_WIDTH,  16'd1,    1'b0, 16'h0000, 1'b0},
			'{ROW_LENGTH, 16'd1,    1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000, 1'b1},
			'{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
			'{ROW_LENGTH, 16'd0,    1'b0, 16'h0000, 1'b0},
			'{ROW_WIDTH,  16'd0,    1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
			'{ROW_WIDTH,  16'd31,   1'b0, 16'h0000, 1'b0},
			'{ROW_LENGTH, 16'd1,    1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h1234, 1'b1, 16'h1234, 1'b1},
			'{ROW_LENGTH, 16'd3,    1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'hFFFE, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h0003, 1'b0, 16'h0000, 1'b0},
			'{ROW_WIDTH,  16'd4,    1'b0, 16'h0000, 1'b0},
			'{ROW_LENGTH, 16'd5,    1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h0000, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
			'{ROW_WIDTH,  16'd30,   1'b0, 16'h0000, 1'b0},
			'{ROW_LENGTH, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h0010, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'hFFF0, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h0100, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'hF000, 1'b0, 16'h0000, 1'b0},
			'{ROW_WIDTH,  16'd1,    1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h0002, 1'b0, 16'h0000, 1'b0},
			'{ROW_WIDTH,  16'd31,   1'b0, 16'h0000, 1'b0},
			'{ROW_LENGTH, 16'd1,    1'b0, 16'h0000, 1'b0},
			'{ROW_SAMPLE, 16'h4000, 1'b0, 16'h0000, 1'b0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_SAMPLE) begin
				typed_beat.median = plan[r].exp_median;
				typed_beat.eol = plan[r].exp_eol;
				send_sample(plan[r].value, plan[r].typed, typed_beat);
			end else if (plan[r].kind == ROW_WIDTH) begin
				write_reg(REG_WINDOW_WIDTH, plan[r].value);
			end else begin
				write_reg(REG_LINE_LENGTH, plan[r].value);
			end
		end

		// Each phase may reconfigure while idle, then either completes the line
		// and at times more, or stops partway so later settings land mid-line.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 9);
				case (pick)
					0: value = 16'd0;
					1: value = 16'd1;
					2: value = 16'd31;
					3: value = 16'd30;
					default: value = 16'($urandom_range(0, 31));
				endcase
				write_reg(REG_WINDOW_WIDTH, value);
			end
			if ($urandom_range(0, 1) == 0) begin
				pick = $urandom_range(0, 19);
				case (pick)
					0: value = 16'd0;
					1: value = 16'hFFFF;
					2: value = 16'd256;
					3, 4, 5: value = 16'($urandom_range(1, 4));
					default: value = 16'($urandom_range(1, 40));
				endcase
				write_reg(REG_LINE_LENGTH, value);
			end
			eff_len = (length_reg == 16'd0) ? 1 : int'(length_reg);
			left = eff_len - line_pos;
			if (left < 1) begin
				left = 1;
			end
			if (left > 48 || $urandom_range(0, 3) == 0) begin
				count = $urandom_range(1, (left < 24) ? left : 24);
			end else begin
				count = left;
				if (eff_len <= 16 && $urandom_range(0, 1) == 1) begin
					count += eff_len * $urandom_range(1, 3);
				end
			end
			mode = $urandom_range(0, 3);
			base = 16'($urandom);
			ramp_step = $urandom_range(0, 2000) - 1000;
			for (int i = 0; i < count; i++) begin
				case (mode)
					0: value = 16'($urandom);
					1: value = 16'($urandom_range(0, 8) - 4);
					2: begin
						case ($urandom_range(0, 4))
							0: value = 16'h8000;
							1: value = 16'h7FFF;
							2: value = 16'h0000;
							3: value = 16'hFFFF;
							default: value = 16'($urandom);
						endcase
					end
					default: value = 16'(int'(base) + i * ramp_step);
				endcase
				send_sample(value, 1'b0, blank);
				sent++;
			end
		end

		samples.valid <= 1'b0;
		settle();
		if (errors == 0) begin
			$display("running_median_filter_1d test passed");
		end else begin
			$display("running_median_filter_1d test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
design/rmf_pkg.sv
design/rmf_if.sv
design/rmf_sort_cell.sv
design/rmf_sort_chain.sv
design/rmf_addr_gen.sv
design/running_median_filter_1d.sv
bench/tb_top.sv
